[hw/rtl/ddd_pkg.sv]
`default_nettype none

package ddd_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MIN_W    = 6;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned DIFF_W   = 22;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 14;

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [HOUR_W-1:0]  HOUR_MAX   = 5'd23;
    localparam logic [MIN_W-1:0]   MINSEC_MAX = 6'd59;
    localparam logic [DIFF_W-1:0]  DIFF_MAX   = 22'd3652058;

    localparam logic [YEAR_W-1:0]  REF_YEAR_RST  = 14'd2000;
    localparam logic [MONTH_W-1:0] REF_MONTH_RST = 4'd1;
    localparam logic [DAY_W-1:0]   REF_DAY_RST   = 5'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DATE_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TIME_ERR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_REF_YEAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_MONTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_DAY   = 2'd2;

    // floor(p / 100) = (p * RECIP_100) >> RECIP_SHIFT for p below 2**14
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam logic [8:0]  DAYS_YEAR   = 9'd365;
    localparam logic [6:0]  HUNDRED     = 7'd100;

    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] n;
        begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
                4'd2:                                        n = leap ? 5'd29 : 5'd28;
                default:                                     n = 5'd0;
            endcase
            return n;
        end
    endfunction

    function automatic logic [8:0] f_days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        begin
            case (m)
                4'd1:    n = 9'd0;
                4'd2:    n = 9'd31;
                4'd3:    n = 9'd59;
                4'd4:    n = 9'd90;
                4'd5:    n = 9'd120;
                4'd6:    n = 9'd151;
                4'd7:    n = 9'd181;
                4'd8:    n = 9'd212;
                4'd9:    n = 9'd243;
                4'd10:   n = 9'd273;
                4'd11:   n = 9'd304;
                4'd12:   n = 9'd334;
                default: n = 9'd0;
            endcase
            return n;
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/date_day_difference_top.sv]
// Date day difference: absolute day count between each input date and a
// programmed reference date, proleptic Gregorian calendar.
//
// Input channel: i_valid / o_stall with year, month, day, hour, minute and
// second fields. Output channel: o_valid / i_stall with status (ok, date
// error, time error) and the day difference, 0 unless status is ok.
// Configuration: i_cfg_valid / o_cfg_ready with register index and data;
// index 0 year, 1 month, 2 day of the reference date. Ready is always high.
// Write the reference only with no word in flight.
//
// o_valid rises once an accepted word has passed through all the register stages;
// one word per cycle is sustained while i_stall stays low. Four register stages:
// the 365 and reciprocal-of-100 products, the century and leap terms, the
// month offset and range checks, and the final subtract and compare. Item and
// reference run through twin lanes.
// Reset empties the pipeline and loads the reference 2000-01-01. While the
// receiver stalls, o_valid and the result hold; empty stages keep filling,
// and o_stall rises only once all four stages hold words.
`default_nettype none

module date_day_difference_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_stall,
    input  wire  [ddd_pkg::YEAR_W-1:0]        i_year_in,
    input  wire  [ddd_pkg::MONTH_W-1:0]       i_month_in,
    input  wire  [ddd_pkg::DAY_W-1:0]         i_day_in,
    input  wire  [ddd_pkg::HOUR_W-1:0]        i_hour_in,
    input  wire  [ddd_pkg::MIN_W-1:0]         i_minute_in,
    input  wire  [ddd_pkg::SEC_W-1:0]         i_second_in,
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic [ddd_pkg::STATUS_W-1:0]      o_status,
    output logic [ddd_pkg::DIFF_W-1:0]        o_day_diff,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [ddd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [ddd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned LANES = 2;

    logic [ddd_pkg::YEAR_W-1:0]  r_ref_year;
    logic [ddd_pkg::MONTH_W-1:0] r_ref_month;
    logic [ddd_pkg::DAY_W-1:0]   r_ref_day;

    logic [ddd_pkg::YEAR_W-1:0]  lane_year  [LANES];
    logic [ddd_pkg::MONTH_W-1:0] lane_month [LANES];
    logic [ddd_pkg::DAY_W-1:0]   lane_day   [LANES];

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1
    logic [13:0]                  n_p1      [LANES];
    logic [21:0]                  n_prod365 [LANES];
    logic [26:0]                  n_prod100 [LANES];
    logic                         n_yok1    [LANES];
    logic [13:0]                  r_p1      [LANES];
    logic [21:0]                  r_prod365 [LANES];
    logic [26:0]                  r_prod100 [LANES];
    logic                         r_yok1    [LANES];
    logic [ddd_pkg::MONTH_W-1:0]  r_m1      [LANES];
    logic [ddd_pkg::DAY_W-1:0]    r_d1      [LANES];
    logic                         n_tok1;
    logic                         r_tok1;

    // stage 2
    logic [7:0]                   n_qp2  [LANES];
    logic [13:0]                  n_rp2  [LANES];
    logic                         n_leap2 [LANES];
    logic [21:0]                  n_n2   [LANES];
    logic                         r_leap2 [LANES];
    logic [21:0]                  r_n2   [LANES];
    logic                         r_yok2 [LANES];
    logic [ddd_pkg::MONTH_W-1:0]  r_m2   [LANES];
    logic [ddd_pkg::DAY_W-1:0]    r_d2   [LANES];
    logic                         r_tok2;

    // stage 3
    logic [ddd_pkg::DAY_W-1:0]    n_dim3 [LANES];
    logic                         n_ok3  [LANES];
    logic [21:0]                  n_n3   [LANES];
    logic                         r_ok3  [LANES];
    logic [21:0]                  r_n3   [LANES];
    logic                         r_tok3;

    // stage 4
    logic [ddd_pkg::STATUS_W-1:0] n_status;
    logic [ddd_pkg::DIFF_W-1:0]   n_diff;
    logic [ddd_pkg::STATUS_W-1:0] r_status;
    logic [ddd_pkg::DIFF_W-1:0]   r_diff;

    assign rdy4 = !r_v4 || !i_stall;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_stall     = !rdy1;
    assign o_valid     = r_v4;
    assign o_status    = r_status;
    assign o_day_diff  = r_diff;
    assign o_cfg_ready = 1'b1;

    assign lane_year[0]  = i_year_in;
    assign lane_month[0] = i_month_in;
    assign lane_day[0]   = i_day_in;
    assign lane_year[1]  = r_ref_year;
    assign lane_month[1] = r_ref_month;
    assign lane_day[1]   = r_ref_day;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_year  <= ddd_pkg::REF_YEAR_RST;
            r_ref_month <= ddd_pkg::REF_MONTH_RST;
            r_ref_day   <= ddd_pkg::REF_DAY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ddd_pkg::REG_REF_YEAR:  r_ref_year  <= i_cfg_data;
                ddd_pkg::REG_REF_MONTH: r_ref_month <= i_cfg_data[ddd_pkg::MONTH_W-1:0];
                ddd_pkg::REG_REF_DAY:   r_ref_day   <= i_cfg_data[ddd_pkg::DAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_p1[k]      = lane_year[k] - 14'd1;
            n_prod365[k] = 22'(n_p1[k]) * 22'(ddd_pkg::DAYS_YEAR);
            n_prod100[k] = 27'(n_p1[k]) * 27'(ddd_pkg::RECIP_100);
            n_yok1[k]    = (lane_year[k] != 14'd0) && (lane_year[k] <= ddd_pkg::YEAR_MAX);
        end
        n_tok1 = (i_hour_in <= ddd_pkg::HOUR_MAX) && (i_minute_in <= ddd_pkg::MINSEC_MAX)
              && (i_second_in <= ddd_pkg::MINSEC_MAX);
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_qp2[k]   = r_prod100[k][ddd_pkg::RECIP_SHIFT +: 8];
            n_rp2[k]   = r_p1[k] - (14'(n_qp2[k]) * 14'(ddd_pkg::HUNDRED));
            // year = p + 1: leap when p % 4 == 3, unless p % 100 == 99 and p % 400 != 399
            n_leap2[k] = (r_p1[k][1:0] == 2'b11)
                      && ((n_rp2[k] != 14'd99) || (n_qp2[k][1:0] == 2'b11));
            n_n2[k]    = r_prod365[k] + 22'(r_p1[k][13:2]) - 22'(n_qp2[k])
                       + 22'(n_qp2[k][7:2]);
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_dim3[k] = ddd_pkg::f_month_len(r_m2[k], r_leap2[k]);
            n_ok3[k]  = r_yok2[k] && (r_d2[k] != 5'd0) && (r_d2[k] <= n_dim3[k]);
            n_n3[k]   = r_n2[k] + 22'(ddd_pkg::f_days_before(r_m2[k]))
                      + 22'(r_leap2[k] && (r_m2[k] > 4'd2)) + 22'(r_d2[k]);
        end
    end

    always_comb begin
        n_status = ddd_pkg::STATUS_OK;
        n_diff   = (r_n3[0] > r_n3[1]) ? (r_n3[0] - r_n3[1]) : (r_n3[1] - r_n3[0]);
        if (!r_ok3[0] || !r_ok3[1]) begin
            n_status = ddd_pkg::STATUS_DATE_ERR;
            n_diff   = '0;
        end else if (!r_tok3) begin
            n_status = ddd_pkg::STATUS_TIME_ERR;
            n_diff   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            for (int k = 0; k < LANES; k++) begin
                r_p1[k]      <= n_p1[k];
                r_prod365[k] <= n_prod365[k];
                r_prod100[k] <= n_prod100[k];
                r_yok1[k]    <= n_yok1[k];
                r_m1[k]      <= lane_month[k];
                r_d1[k]      <= lane_day[k];
            end
            r_tok1 <= n_tok1;
        end
        if (rdy2) begin
            for (int k = 0; k < LANES; k++) begin
                r_leap2[k] <= n_leap2[k];
                r_n2[k]    <= n_n2[k];
                r_yok2[k]  <= r_yok1[k];
                r_m2[k]    <= r_m1[k];
                r_d2[k]    <= r_d1[k];
            end
            r_tok2 <= r_tok1;
        end
        if (rdy3) begin
            for (int k = 0; k < LANES; k++) begin
                r_ok3[k] <= n_ok3[k];
                r_n3[k]  <= n_n3[k];
            end
            r_tok3 <= r_tok2;
        end
        if (rdy4) begin
            r_status <= n_status;
            r_diff   <= n_diff;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ddd_checker.sv]
`default_nettype none

module ddd_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_valid,
    input wire                          i_stall,
    input wire [ddd_pkg::STATUS_W-1:0]  o_status,
    input wire [ddd_pkg::DIFF_W-1:0]    o_day_diff
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word present after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ddd_pkg::STATUS_OK) || (o_status == ddd_pkg::STATUS_DATE_ERR)
                    || (o_status == ddd_pkg::STATUS_TIME_ERR))
        else $error("undefined status code");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ddd_pkg::STATUS_OK) |-> (o_day_diff == '0))
        else $error("nonzero difference on error word");

    a_diff_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ddd_pkg::STATUS_OK) |-> (o_day_diff <= ddd_pkg::DIFF_MAX))
        else $error("difference beyond calendar span");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_day_diff))
        else $error("stalled output word changed");

endmodule

bind date_day_difference_top ddd_checker u_ddd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_status   (o_status),
    .o_day_diff (o_day_diff)
);

`default_nettype wire

[tb/sv/date_day_difference_checker.sv]
`default_nettype none

module date_day_difference_checker (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    input  wire                           o_stall,
    input  wire [ddd_pkg::YEAR_W-1:0]     i_year_in,
    input  wire [ddd_pkg::MONTH_W-1:0]    i_month_in,
    input  wire [ddd_pkg::DAY_W-1:0]      i_day_in,
    input  wire [ddd_pkg::HOUR_W-1:0]     i_hour_in,
    input  wire [ddd_pkg::MIN_W-1:0]      i_minute_in,
    input  wire [ddd_pkg::SEC_W-1:0]      i_second_in,
    input  wire                           o_valid,
    input  wire                           i_stall,
    input  wire [ddd_pkg::STATUS_W-1:0]   o_status,
    input  wire [ddd_pkg::DIFF_W-1:0]     o_day_diff,
    input  wire                           i_cfg_valid,
    input  wire                           o_cfg_ready,
    input  wire [ddd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [ddd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                            mismatch_count,
    output int                            words_pending
);

    typedef logic [ddd_pkg::DIFF_W-1:0] t_diff;

    typedef struct packed {
        logic [ddd_pkg::STATUS_W-1:0] status;
        logic [ddd_pkg::DIFF_W-1:0]   day_diff;
    } t_day_result;

    t_day_result                   expected_q[$];
    logic [ddd_pkg::YEAR_W-1:0]    ref_yr  = ddd_pkg::REF_YEAR_RST;
    logic [ddd_pkg::MONTH_W-1:0]   ref_mon = ddd_pkg::REF_MONTH_RST;
    logic [ddd_pkg::DAY_W-1:0]     ref_dy  = ddd_pkg::REF_DAY_RST;

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
        int unsigned n;
        case (m)
            2:             n = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   n = 30;
            default:       n = 31;
        endcase
        return n;
    endfunction

    function automatic bit real_date(input int unsigned y, input int unsigned m,
                                     input int unsigned d);
        if (y < 1 || y > ddd_pkg::YEAR_MAX || m < 1 || m > 12)
            return 1'b0;
        return (d >= 1) && (d <= month_days(y, m));
    endfunction

    function automatic int unsigned day_count(input int unsigned y, input int unsigned m,
                                              input int unsigned d);
        int unsigned p;
        int unsigned n;
        p = y - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < m; k++)
            n += month_days(y, k);
        return n + d;
    endfunction

    function automatic t_day_result day_distance(input int unsigned y, input int unsigned m,
                                                 input int unsigned d, input int unsigned h,
                                                 input int unsigned mi, input int unsigned s);
        t_day_result r;
        int unsigned a;
        int unsigned b;
        r.status   = ddd_pkg::STATUS_OK;
        r.day_diff = '0;
        if (!real_date(y, m, d) || !real_date(32'(ref_yr), 32'(ref_mon), 32'(ref_dy))) begin
            r.status = ddd_pkg::STATUS_DATE_ERR;
        end else if (h > ddd_pkg::HOUR_MAX || mi > ddd_pkg::MINSEC_MAX
                     || s > ddd_pkg::MINSEC_MAX) begin
            r.status = ddd_pkg::STATUS_TIME_ERR;
        end else begin
            a = day_count(y, m, d);
            b = day_count(32'(ref_yr), 32'(ref_mon), 32'(ref_dy));
            r.day_diff = t_diff'((a > b) ? (a - b) : (b - a));
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_day_result want;
        if (!i_rst_n) begin
            ref_yr  = ddd_pkg::REF_YEAR_RST;
            ref_mon = ddd_pkg::REF_MONTH_RST;
            ref_dy  = ddd_pkg::REF_DAY_RST;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ddd_pkg::REG_REF_YEAR:  ref_yr  = i_cfg_data[ddd_pkg::YEAR_W-1:0];
                    ddd_pkg::REG_REF_MONTH: ref_mon = i_cfg_data[ddd_pkg::MONTH_W-1:0];
                    ddd_pkg::REG_REF_DAY:   ref_dy  = i_cfg_data[ddd_pkg::DAY_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                expected_q.push_back(day_distance(32'(i_year_in), 32'(i_month_in),
                                                  32'(i_day_in), 32'(i_hour_in),
                                                  32'(i_minute_in), 32'(i_second_in)));
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result word with no date outstanding: status %0d day_diff %0d",
                           o_status, o_day_diff);
                    mismatch_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (o_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, o_status);
                        mismatch_count++;
                    end
                    if (o_day_diff !== want.day_diff) begin
                        $error("day_diff mismatch: expected %0d, actual %0d",
                               want.day_diff, o_day_diff);
                        mismatch_count++;
                    end
                end
            end
        end
        words_pending <= expected_q.size();
    end

endmodule

`default_nettype wire

[tb/sv/date_day_difference_top_tb.sv]
`default_nettype none

module date_day_difference_top_tb;

    typedef logic [ddd_pkg::YEAR_W-1:0]     t_year;
    typedef logic [ddd_pkg::MONTH_W-1:0]    t_month;
    typedef logic [ddd_pkg::DAY_W-1:0]      t_day;
    typedef logic [ddd_pkg::HOUR_W-1:0]     t_hour;
    typedef logic [ddd_pkg::MIN_W-1:0]      t_min;
    typedef logic [ddd_pkg::SEC_W-1:0]      t_sec;
    typedef logic [ddd_pkg::CFG_DATA_W-1:0] t_cfg_data;

    localparam logic [ddd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_valid     = 1'b0;
    logic                           o_stall;
    logic [ddd_pkg::YEAR_W-1:0]     i_year_in   = '0;
    logic [ddd_pkg::MONTH_W-1:0]    i_month_in  = '0;
    logic [ddd_pkg::DAY_W-1:0]      i_day_in    = '0;
    logic [ddd_pkg::HOUR_W-1:0]     i_hour_in   = '0;
    logic [ddd_pkg::MIN_W-1:0]      i_minute_in = '0;
    logic [ddd_pkg::SEC_W-1:0]      i_second_in = '0;
    logic                           o_valid;
    logic                           i_stall     = 1'b0;
    logic [ddd_pkg::STATUS_W-1:0]   o_status;
    logic [ddd_pkg::DIFF_W-1:0]     o_day_diff;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [ddd_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [ddd_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    int          mismatch_count;
    int          words_pending;
    int unsigned send_idle   = 0;
    int unsigned stall_pct   = 0;
    int unsigned cycle_count = 0;

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall     <= ($urandom_range(99) < stall_pct);
        cycle_count <= cycle_count + 1;
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    date_day_difference_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_year_in   (i_year_in),
        .i_month_in  (i_month_in),
        .i_day_in    (i_day_in),
        .i_hour_in   (i_hour_in),
        .i_minute_in (i_minute_in),
        .i_second_in (i_second_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_day_diff  (o_day_diff),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    date_day_difference_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_year_in      (i_year_in),
        .i_month_in     (i_month_in),
        .i_day_in       (i_day_in),
        .i_hour_in      (i_hour_in),
        .i_minute_in    (i_minute_in),
        .i_second_in    (i_second_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_day_diff     (o_day_diff),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    task automatic send_date(input t_year y, input t_month m, input t_day d,
                             input t_hour h, input t_min mi, input t_sec s);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_year_in   <= y;
        i_month_in  <= m;
        i_day_in    <= d;
        i_hour_in   <= h;
        i_minute_in <= mi;
        i_second_in <= s;
        do @(posedge i_clk); while (o_stall);
    endtask

    // hold the sender until every result has come back, then let the pipe settle
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (words_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ddd_pkg::CFG_IDX_W-1:0] idx,
                             input t_cfg_data data);
        hold_until_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_reference(input t_year y, input t_month m, input t_day d);
        write_reg(ddd_pkg::REG_REF_YEAR, y);
        write_reg(ddd_pkg::REG_REF_MONTH, {10'($urandom), m});
        write_reg(ddd_pkg::REG_REF_DAY, {9'($urandom), d});
    endtask

    task automatic send_random();
        t_year       y;
        t_month      m;
        t_day        d;
        t_hour       h;
        t_min        mi;
        t_sec        s;
        int unsigned pick;
        case ($urandom_range(9))
            0:       y = t_year'(1);
            1:       y = ddd_pkg::YEAR_MAX;
            2:       y = t_year'($urandom_range(1, 24) * 400 - $urandom_range(0, 1) * 100);
            3, 4:    y = t_year'(1990 + $urandom_range(0, 20));
            default: y = t_year'($urandom_range(1, ddd_pkg::YEAR_MAX));
        endcase
        m  = t_month'($urandom_range(1, 12));
        d  = t_day'(($urandom_range(3) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 28));
        h  = t_hour'($urandom_range(0, ddd_pkg::HOUR_MAX));
        mi = t_min'($urandom_range(0, ddd_pkg::MINSEC_MAX));
        s  = t_sec'($urandom_range(0, ddd_pkg::MINSEC_MAX));
        pick = $urandom_range(99);
        if (pick >= 62 && pick < 78) begin
            case ($urandom_range(3))
                0:       h  = t_hour'($urandom_range(ddd_pkg::HOUR_MAX + 1, 31));
                1:       mi = t_min'($urandom_range(ddd_pkg::MINSEC_MAX + 1, 63));
                2:       s  = t_sec'($urandom_range(ddd_pkg::MINSEC_MAX + 1, 63));
                default: begin
                    h  = t_hour'($urandom);
                    mi = t_min'($urandom);
                    s  = t_sec'($urandom);
                end
            endcase
        end else if (pick >= 78 && pick < 86) begin
            case ($urandom_range(3))
                0:       m = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
                1:       d = 5'd0;
                2:       y = $urandom_range(0, 1) ? 14'd0 : 14'($urandom_range(10000, 16383));
                default: h = t_hour'($urandom);
            endcase
        end else if (pick >= 86) begin
            y  = t_year'($urandom);
            m  = t_month'($urandom);
            d  = t_day'($urandom);
            h  = t_hour'($urandom);
            mi = t_min'($urandom);
            s  = t_sec'($urandom);
        end
        send_date(y, m, d, h, mi, s);
    endtask

    task automatic run_phase(input int unsigned n, input int unsigned idle_pct,
                             input int unsigned stall_in);
        send_idle = idle_pct;
        stall_pct <= stall_in;
        send_date(1, 1, 1, 0, 0, 0);
        send_date(ddd_pkg::YEAR_MAX, 12, 31, 23, 59, 59);
        repeat (n) send_random();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_date(1, 1, 1, 0, 0, 0);
        send_date(ddd_pkg::YEAR_MAX, 12, 31, 23, 59, 59);
        send_date(2000, 1, 1, 12, 30, 30);
        send_date(2000, 2, 29, 0, 0, 0);
        send_date(1900, 2, 29, 0, 0, 0);
        send_date(2100, 2, 29, 0, 0, 0);
        send_date(2400, 2, 29, 0, 0, 0);
        send_date(2004, 2, 29, 0, 0, 0);
        send_date(2001, 2, 29, 0, 0, 0);
        send_date(2001, 2, 28, 0, 0, 0);
        send_date(2023, 4, 31, 0, 0, 0);
        send_date(2023, 5, 0, 0, 0, 0);
        send_date(2023, 0, 10, 0, 0, 0);
        send_date(2023, 13, 10, 0, 0, 0);
        send_date(2023, 15, 31, 0, 0, 0);
        send_date(0, 6, 15, 0, 0, 0);
        send_date(10000, 1, 1, 0, 0, 0);
        send_date(16383, 12, 31, 0, 0, 0);
        send_date(2023, 6, 15, 24, 0, 0);
        send_date(2023, 6, 15, 0, 60, 0);
        send_date(2023, 6, 15, 0, 0, 60);
        send_date(2023, 6, 15, 31, 63, 63);
        send_date(2023, 0, 15, 31, 63, 63);
        send_date(1999, 12, 31, 23, 59, 59);

        run_phase(200, 0, 0);

        set_reference(1, 1, 1);
        run_phase(115, 61, 0);
        hold_until_drained();
        run_phase(115, 61, 0);

        set_reference(ddd_pkg::YEAR_MAX, 12, 31);
        run_phase(200, 0, 61);

        set_reference(2000, 2, 29);
        run_phase(200, 27, 27);

        set_reference(2023, 13, 10);
        run_phase(30, 27, 27);
        set_reference(0, 6, 15);
        run_phase(30, 0, 0);
        set_reference(1900, 2, 29);
        run_phase(30, 61, 0);
        set_reference(10000, 4, 31);
        run_phase(30, 0, 61);

        set_reference(t_year'($urandom_range(1, ddd_pkg::YEAR_MAX)),
                      t_month'($urandom_range(1, 12)), t_day'($urandom_range(1, 28)));
        write_reg(REG_UNUSED, t_cfg_data'($urandom));
        run_phase(200, 27, 27);

        hold_until_drained();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/ddd_pkg.sv
hw/rtl/date_day_difference_top.sv
hw/rtl/ddd_checker.sv
tb/sv/date_day_difference_checker.sv
tb/sv/date_day_difference_top_tb.sv
